### design/ttvh_pkg.sv
`timescale 1ns / 1ps

package ttvh_pkg;

  // field widths
  localparam int OP_W      = 2;
  localparam int IDX_W     = 12;
  localparam int TIME_W    = 16;
  localparam int VEL_W     = 24;
  localparam int BIN_W     = 8;
  localparam int CNT_W     = 32;
  localparam int STAT_W    = 3;

  // configuration port
  localparam int WIN_W     = 48;
  localparam int SPAN_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_WIN_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN     = 2'd2;

  localparam logic signed [WIN_W-1:0] WIN_LOW_RST  = 48'sh0000_0000_0000;
  localparam logic signed [WIN_W-1:0] WIN_HIGH_RST = 48'sh0001_0000_0000;
  localparam logic [SPAN_W-1:0]       SPAN_RST     = 16'd1000;

  // signed square of the velocity (Q16.32) and derived arithmetic widths
  localparam int SQ_W   = 48;
  localparam int DIFF_W = 49;
  localparam int MAG_W  = 48;
  localparam int SLOT_W = TIME_W + SQ_W;

  // conditional subtract steps that fold a 12-bit index into at least 16 slots
  localparam int MOD_STEPS = 8;

  typedef enum logic [OP_W-1:0] {
    OP_RECORD = 2'd0,
    OP_EXIT   = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_RECORDED = 3'd0,
    ST_BINNED   = 3'd1,
    ST_OUTSIDE  = 3'd2,
    ST_NO_ENTRY = 3'd3,
    ST_CLEARED  = 3'd4,
    ST_READ     = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RECORD,
    S_SLOT_RD,
    S_SLOT_CHK,
    S_ABS,
    S_SCALE,
    S_TSTART,
    S_TDIV,
    S_VSTART,
    S_VDIV,
    S_BIN,
    S_RD_ADDR,
    S_HIST_RD,
    S_HIST_UPD,
    S_DONE
  } state_e;

endpackage

### design/ttvh_div.sv
`timescale 1ns / 1ps

module ttvh_div #(
  parameter int NUM_W = 56,
  parameter int DEN_W = 48
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [NUM_W-1:0]  acc_q, acc_d;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              qbit;

  // restoring division, one quotient bit per cycle, msb first
  always_comb begin
    trial  = {rem_q, acc_q[NUM_W-1]};
    diff   = trial - {1'b0, den_q};
    qbit   = ~diff[DEN_W];
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(NUM_W);
      acc_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d  = qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      acc_d  = {acc_q[NUM_W-2:0], qbit};
      step_d = step_q - 1'b1;
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = acc_q;

endmodule

### design/transit_time_velocity_histogram_top.sv
// record: slot write, then result; read: address check, memory read, then result;
//   exit: slot read and check, then time and velocity bins on the shared bit-serial
//   divider, then histogram increment; clear: one memory row per cycle over the larger
//   of SLOTS and VEL_BINS*TIME_BINS; one word in flight; the next word is taken the
//   cycle after a result is registered; reset: async, active low; then a clearing pass
//   over those rows runs before the first word is taken
`timescale 1ns / 1ps

module transit_time_velocity_histogram_top #(
  parameter int SLOTS     = 4096,
  parameter int VEL_BINS  = 200,
  parameter int TIME_BINS = 200
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [ttvh_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ttvh_pkg::CFG_DAT_W-1:0]      cfg_data_i,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [ttvh_pkg::OP_W-1:0]           operation_i,
  input  logic [ttvh_pkg::IDX_W-1:0]          particle_index_i,
  input  logic [ttvh_pkg::TIME_W-1:0]         time_now_i,
  input  logic signed [ttvh_pkg::VEL_W-1:0]   velocity_i,
  input  logic [ttvh_pkg::BIN_W-1:0]          vel_bin_i,
  input  logic [ttvh_pkg::BIN_W-1:0]          time_bin_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [ttvh_pkg::CNT_W-1:0]          count_o,
  output logic [ttvh_pkg::STAT_W-1:0]         status_o
);

  import ttvh_pkg::*;

  localparam int HIST_D = VEL_BINS * TIME_BINS;
  localparam int SA_W   = $clog2(SLOTS);
  localparam int HA_W   = $clog2(HIST_D);
  localparam int VB_W   = $clog2(VEL_BINS);
  localparam int TB_W   = $clog2(TIME_BINS);
  localparam int MUL_W  = $clog2((VEL_BINS > TIME_BINS) ? VEL_BINS : TIME_BINS);
  localparam int NUM_W  = MAG_W + MUL_W;
  localparam int CLR_D  = (SLOTS > HIST_D) ? SLOTS : HIST_D;
  localparam int CW     = $clog2(CLR_D);

  localparam logic [MUL_W-1:0] VMUL_C    = MUL_W'(VEL_BINS - 1);
  localparam logic [MUL_W-1:0] TMUL_C    = MUL_W'(TIME_BINS - 1);
  localparam logic [HA_W-1:0]  TB_C      = HA_W'(TIME_BINS);
  localparam logic [CW-1:0]    CLR_LAST  = CW'(CLR_D - 1);
  localparam logic [CW:0]      CLR_SLOTS = (CW + 1)'(SLOTS);
  localparam logic [CW:0]      CLR_HIST  = (CW + 1)'(HIST_D);

  // configuration registers
  logic signed [WIN_W-1:0] win_low_q, win_high_q;
  logic [SPAN_W-1:0]       span_q;

  // control state
  state_e        state_q, state_d;
  logic [CW-1:0] clr_cnt_q, clr_cnt_d;
  logic          clr_reply_q, clr_reply_d;
  logic          out_valid_q, out_valid_d;

  // captured word
  op_e                     op_q, op_d;
  logic [SA_W-1:0]         slot_q, slot_d;
  logic [TIME_W-1:0]       now_q, now_d;
  logic signed [VEL_W-1:0] vel_q, vel_d;
  logic [BIN_W-1:0]        vb_q, vb_d;
  logic [BIN_W-1:0]        tb_q, tb_d;

  // exit datapath
  logic signed [TIME_W:0]   tdiff_q, tdiff_d;
  logic signed [DIFF_W-1:0] vdiff_q, vdiff_d;
  logic signed [DIFF_W-1:0] wid_q, wid_d;
  logic                     tneg_q, tneg_d;
  logic                     vneg_q, vneg_d;
  logic                     wneg_q, wneg_d;
  logic [TIME_W-1:0]        tmag_q, tmag_d;
  logic [MAG_W-1:0]         vmag_q, vmag_d;
  logic [MAG_W-1:0]         wmag_q, wmag_d;
  logic [NUM_W-1:0]         tnum_q, tnum_d;
  logic [NUM_W-1:0]         vnum_q, vnum_d;
  logic [TB_W-1:0]          it_q, it_d;
  logic [VB_W-1:0]          iv_q, iv_d;
  logic [HA_W-1:0]          hist_addr_q, hist_addr_d;

  // pending result and output register
  logic [CNT_W-1:0] res_count_q, res_count_d;
  status_e          res_status_q, res_status_d;
  logic [CNT_W-1:0] count_q, count_d;
  status_e          status_q, status_d;

  // memories
  logic [SLOT_W-1:0] slot_mem [SLOTS];
  logic [CNT_W-1:0]  hist_mem [HIST_D];
  logic [SLOT_W-1:0] slot_rd_q;
  logic [CNT_W-1:0]  hist_rd_q;
  logic              slot_we, hist_we;
  logic [SA_W-1:0]   slot_wa;
  logic [HA_W-1:0]   hist_wa;
  logic [SLOT_W-1:0] slot_wd;
  logic [CNT_W-1:0]  hist_wd;

  // divider hookup
  logic             div_start, div_done;
  logic [NUM_W-1:0] div_num, div_quot;
  logic [MAG_W-1:0] div_den;

  // misc combinational
  logic                    in_accept, out_free;
  logic [IDX_W-1:0]        slot_rem;
  logic [VEL_W-1:0]        vel_mag;
  logic [SQ_W-1:0]         sq_mag;
  logic [SQ_W-1:0]         sq_val;
  logic [TIME_W-1:0]       ent_time;
  logic signed [SQ_W-1:0]  ent_sq;
  logic [CNT_W-1:0]        hist_inc;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign ent_time = slot_rd_q[SLOT_W-1:SQ_W];
  assign ent_sq   = slot_rd_q[SQ_W-1:0];

  // fold the particle index into the slot range
  always_comb begin
    slot_rem = particle_index_i;
    for (int k = MOD_STEPS - 1; k >= 0; k--) begin
      if (32'(slot_rem) >= (32'(SLOTS) << k)) begin
        slot_rem = slot_rem - IDX_W'(32'(SLOTS) << k);
      end
    end
  end

  // signed square of the entry velocity
  always_comb begin
    vel_mag = vel_q[VEL_W-1] ? VEL_W'(-vel_q) : VEL_W'(vel_q);
    sq_mag  = SQ_W'(vel_mag) * SQ_W'(vel_mag);
    sq_val  = vel_q[VEL_W-1] ? -sq_mag : sq_mag;
  end

  // saturating increment of the cell just read
  assign hist_inc = (hist_rd_q == '1) ? hist_rd_q : hist_rd_q + 1'b1;

  // divider operands
  assign div_start = (state_q == S_TSTART) || (state_q == S_VSTART);
  assign div_num   = (state_q == S_TSTART) ? tnum_q : vnum_q;
  assign div_den   = (state_q == S_TSTART) ? MAG_W'(span_q) : wmag_q;

  ttvh_div #(
    .NUM_W (NUM_W),
    .DEN_W (MAG_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // sequencer: next state, datapath and memory writes
  always_comb begin
    state_d      = state_q;
    clr_cnt_d    = clr_cnt_q;
    clr_reply_d  = clr_reply_q;
    out_valid_d  = out_valid_q && out_stall_i;
    op_d         = op_q;
    slot_d       = slot_q;
    now_d        = now_q;
    vel_d        = vel_q;
    vb_d         = vb_q;
    tb_d         = tb_q;
    tdiff_d      = tdiff_q;
    vdiff_d      = vdiff_q;
    wid_d        = wid_q;
    tneg_d       = tneg_q;
    vneg_d       = vneg_q;
    wneg_d       = wneg_q;
    tmag_d       = tmag_q;
    vmag_d       = vmag_q;
    wmag_d       = wmag_q;
    tnum_d       = tnum_q;
    vnum_d       = vnum_q;
    it_d         = it_q;
    iv_d         = iv_q;
    hist_addr_d  = hist_addr_q;
    res_count_d  = res_count_q;
    res_status_d = res_status_q;
    count_d      = count_q;
    status_d     = status_q;
    slot_we      = 1'b0;
    slot_wa      = slot_q;
    slot_wd      = {now_q, sq_val};
    hist_we      = 1'b0;
    hist_wa      = hist_addr_q;
    hist_wd      = hist_inc;

    case (state_q)
      // zero both memories one row per cycle
      S_CLEAR: begin
        slot_we = ({1'b0, clr_cnt_q} < CLR_SLOTS);
        slot_wa = clr_cnt_q[SA_W-1:0];
        slot_wd = '0;
        hist_we = ({1'b0, clr_cnt_q} < CLR_HIST);
        hist_wa = clr_cnt_q[HA_W-1:0];
        hist_wd = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == CLR_LAST) begin
          if (clr_reply_q) begin
            res_count_d  = '0;
            res_status_d = ST_CLEARED;
            state_d      = S_DONE;
          end else begin
            state_d = S_IDLE;
          end
        end
      end

      // take a word and dispatch on the operation
      S_IDLE: begin
        if (in_accept) begin
          op_d   = op_e'(operation_i);
          slot_d = SA_W'(slot_rem);
          now_d  = time_now_i;
          vel_d  = velocity_i;
          vb_d   = vel_bin_i;
          tb_d   = time_bin_i;
          case (op_e'(operation_i))
            OP_RECORD: state_d = S_RECORD;
            OP_EXIT:   state_d = S_SLOT_RD;
            OP_READ:   state_d = S_RD_ADDR;
            OP_CLEAR: begin
              clr_cnt_d   = '0;
              clr_reply_d = 1'b1;
              state_d     = S_CLEAR;
            end
            default:   state_d = S_IDLE;
          endcase
        end
      end

      S_RECORD: begin
        slot_we      = 1'b1;
        res_count_d  = '0;
        res_status_d = ST_RECORDED;
        state_d      = S_DONE;
      end

      S_SLOT_RD: state_d = S_SLOT_CHK;

      // entry check and signed differences
      S_SLOT_CHK: begin
        tdiff_d = $signed({1'b0, now_q}) - $signed({1'b0, ent_time});
        vdiff_d = DIFF_W'(ent_sq) - DIFF_W'(win_low_q);
        wid_d   = DIFF_W'(win_high_q) - DIFF_W'(win_low_q);
        res_count_d = '0;
        if (ent_time == '0) begin
          res_status_d = ST_NO_ENTRY;
          state_d      = S_DONE;
        end else if (span_q == '0 || win_high_q == win_low_q) begin
          res_status_d = ST_OUTSIDE;
          state_d      = S_DONE;
        end else begin
          state_d = S_ABS;
        end
      end

      // sign and magnitude
      S_ABS: begin
        tneg_d  = tdiff_q[TIME_W];
        vneg_d  = vdiff_q[DIFF_W-1];
        wneg_d  = wid_q[DIFF_W-1];
        tmag_d  = tdiff_q[TIME_W] ? TIME_W'(-tdiff_q) : TIME_W'(tdiff_q);
        vmag_d  = vdiff_q[DIFF_W-1] ? MAG_W'(-vdiff_q) : MAG_W'(vdiff_q);
        wmag_d  = wid_q[DIFF_W-1] ? MAG_W'(-wid_q) : MAG_W'(wid_q);
        state_d = S_SCALE;
      end

      // scale by the bin count minus one
      S_SCALE: begin
        tnum_d  = NUM_W'(tmag_q) * NUM_W'(TMUL_C);
        vnum_d  = NUM_W'(vmag_q) * NUM_W'(VMUL_C);
        state_d = S_TSTART;
      end

      S_TSTART: state_d = S_TDIV;

      // time bin must lie strictly inside the edges
      S_TDIV: begin
        if (div_done) begin
          it_d = div_quot[TB_W-1:0];
          if (!tneg_q && div_quot != '0 && div_quot < NUM_W'(TIME_BINS - 1)) begin
            state_d = S_VSTART;
          end else begin
            res_count_d  = '0;
            res_status_d = ST_OUTSIDE;
            state_d      = S_DONE;
          end
        end
      end

      S_VSTART: state_d = S_VDIV;

      // velocity bin, positive only when both signs agree
      S_VDIV: begin
        if (div_done) begin
          iv_d = div_quot[VB_W-1:0];
          if (vneg_q == wneg_q && div_quot != '0 &&
              div_quot < NUM_W'(VEL_BINS - 1)) begin
            state_d = S_BIN;
          end else begin
            res_count_d  = '0;
            res_status_d = ST_OUTSIDE;
            state_d      = S_DONE;
          end
        end
      end

      S_BIN: begin
        hist_addr_d = HA_W'(iv_q) * TB_C + HA_W'(it_q);
        state_d     = S_HIST_RD;
      end

      S_RD_ADDR: begin
        hist_addr_d = HA_W'(vb_q) * TB_C + HA_W'(tb_q);
        if (32'(vb_q) < 32'(VEL_BINS) && 32'(tb_q) < 32'(TIME_BINS)) begin
          state_d = S_HIST_RD;
        end else begin
          res_count_d  = '0;
          res_status_d = ST_READ;
          state_d      = S_DONE;
        end
      end

      S_HIST_RD: state_d = S_HIST_UPD;

      // bump the cell or hand back its count
      S_HIST_UPD: begin
        if (op_q == OP_EXIT) begin
          hist_we      = 1'b1;
          res_count_d  = hist_inc;
          res_status_d = ST_BINNED;
        end else begin
          res_count_d  = hist_rd_q;
          res_status_d = ST_READ;
        end
        state_d = S_DONE;
      end

      // move the result into the output register once it is free
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          count_d     = res_count_q;
          status_d    = res_status_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      clr_reply_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      clr_reply_q <= clr_reply_d;
      out_valid_q <= out_valid_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_low_q  <= WIN_LOW_RST;
      win_high_q <= WIN_HIGH_RST;
      span_q     <= SPAN_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_WIN_LOW:  win_low_q  <= cfg_data_i[WIN_W-1:0];
        CFG_WIN_HIGH: win_high_q <= cfg_data_i[WIN_W-1:0];
        CFG_SPAN:     span_q     <= cfg_data_i[SPAN_W-1:0];
        default:      ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    slot_q       <= slot_d;
    now_q        <= now_d;
    vel_q        <= vel_d;
    vb_q         <= vb_d;
    tb_q         <= tb_d;
    tdiff_q      <= tdiff_d;
    vdiff_q      <= vdiff_d;
    wid_q        <= wid_d;
    tneg_q       <= tneg_d;
    vneg_q       <= vneg_d;
    wneg_q       <= wneg_d;
    tmag_q       <= tmag_d;
    vmag_q       <= vmag_d;
    wmag_q       <= wmag_d;
    tnum_q       <= tnum_d;
    vnum_q       <= vnum_d;
    it_q         <= it_d;
    iv_q         <= iv_d;
    hist_addr_q  <= hist_addr_d;
    res_count_q  <= res_count_d;
    res_status_q <= res_status_d;
    count_q      <= count_d;
    status_q     <= status_d;
  end

  // slot store: entry time and signed square
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    slot_rd_q <= slot_mem[slot_q];
  end

  // histogram store
  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    hist_rd_q <= hist_mem[hist_addr_q];
  end

  assign out_valid_o = out_valid_q;
  assign count_o     = count_q;
  assign status_o    = status_q;

endmodule

### design/ttvh_checker.sv
`timescale 1ns / 1ps

module ttvh_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_i,
  input logic                        out_valid_i,
  input logic                        out_stall_i,
  input logic [ttvh_pkg::CNT_W-1:0]  count_i,
  input logic [ttvh_pkg::STAT_W-1:0] status_i
);

  import ttvh_pkg::*;

  // one word at a time: an accepted word keeps the input stalled next cycle
  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_i |=> in_stall_i
  ) else $error("input taken again right after a word was accepted");

  // the clearing pass holds the input off as reset goes away
  a_clear_after_reset: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> in_stall_i
  ) else $error("word accepted before the clearing pass");

  // a stalled result stays put
  a_out_hold: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(count_i) && $stable(status_i)
  ) else $error("stalled result changed");

  // only binned and read results carry a count
  a_count_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_RECORDED || status_i == ST_OUTSIDE ||
                    status_i == ST_NO_ENTRY || status_i == ST_CLEARED)
    |-> count_i == '0
  ) else $error("nonzero count with a status that has none");

endmodule

bind transit_time_velocity_histogram_top ttvh_checker u_ttvh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .count_i     (count_o),
  .status_i    (status_o)
);

### verif/ttvh_monitor.sv
`timescale 1ns / 1ps

module ttvh_monitor #(
  parameter int SLOTS     = 4096,
  parameter int VEL_BINS  = 200,
  parameter int TIME_BINS = 200
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ttvh_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ttvh_pkg::CFG_DAT_W-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic [ttvh_pkg::OP_W-1:0]           operation_i,
  input  logic [ttvh_pkg::IDX_W-1:0]          particle_index_i,
  input  logic [ttvh_pkg::TIME_W-1:0]         time_now_i,
  input  logic signed [ttvh_pkg::VEL_W-1:0]   velocity_i,
  input  logic [ttvh_pkg::BIN_W-1:0]          vel_bin_i,
  input  logic [ttvh_pkg::BIN_W-1:0]          time_bin_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic [ttvh_pkg::CNT_W-1:0]          count_i,
  input  logic [ttvh_pkg::STAT_W-1:0]         status_i,
  output int                                  fail_count_o,
  output int                                  pending_o,
  output int                                  hits_o
);
  import ttvh_pkg::*;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    status_e          status;
  } bin_word_t;

  // own copy of the block state and registers
  logic [TIME_W-1:0] entry_step [SLOTS];
  longint            entry_sq   [SLOTS];
  logic [CNT_W-1:0]  cells      [VEL_BINS*TIME_BINS];
  longint            win_low;
  longint            win_high;
  logic [SPAN_W-1:0] span;

  bin_word_t awaited_words [$];
  int        mismatches;
  int        checked;
  int        hits;

  // expected result of one word, updating the state as the block would
  function automatic bin_word_t histogram_step(op_e op, logic [IDX_W-1:0] idx,
                                               logic [TIME_W-1:0] now,
                                               logic signed [VEL_W-1:0] vel,
                                               logic [BIN_W-1:0] vb, logic [BIN_W-1:0] tb);
    bin_word_t res;
    longint    v;
    longint    width;
    longint    now_l;
    longint    start_l;
    longint    span_l;
    longint    tbin;
    longint    vbin;
    int        slot;
    int        cell_idx;
    res.count  = '0;
    res.status = ST_READ;
    slot = int'(idx) % SLOTS;
    case (op)
      OP_RECORD: begin
        v = vel;
        entry_sq[slot]   = (v < 0) ? -(v * v) : v * v;
        entry_step[slot] = now;
        res.status       = ST_RECORDED;
      end
      OP_EXIT: begin
        if (entry_step[slot] == '0) begin
          res.status = ST_NO_ENTRY;
        end else begin
          width      = win_high - win_low;
          res.status = ST_OUTSIDE;
          if (span != '0 && width != 0) begin
            now_l   = now;
            start_l = entry_step[slot];
            span_l  = span;
            tbin = (now_l - start_l) * (TIME_BINS - 1) / span_l;
            vbin = (entry_sq[slot] - win_low) * (VEL_BINS - 1) / width;
            if (vbin > 0 && vbin < VEL_BINS - 1 && tbin > 0 && tbin < TIME_BINS - 1) begin
              cell_idx = int'(vbin) * TIME_BINS + int'(tbin);
              // saturating count
              if (cells[cell_idx] != '1) cells[cell_idx] = cells[cell_idx] + 1'b1;
              res.count  = cells[cell_idx];
              res.status = ST_BINNED;
            end
          end
        end
      end
      OP_READ: begin
        if (int'(vb) < VEL_BINS && int'(tb) < TIME_BINS)
          res.count = cells[int'(vb) * TIME_BINS + int'(tb)];
        res.status = ST_READ;
      end
      default: begin
        foreach (entry_step[i]) entry_step[i] = '0;
        foreach (cells[i]) cells[i] = '0;
        res.status = ST_CLEARED;
      end
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bin_word_t want;
    if (!rst_ni) begin
      foreach (entry_step[i]) entry_step[i] = '0;
      foreach (entry_sq[i]) entry_sq[i] = 0;
      foreach (cells[i]) cells[i] = '0;
      win_low  = 0;
      win_high = 64'sd4294967296;
      span     = 16'd1000;
      awaited_words.delete();
      mismatches = 0;
      checked    = 0;
      hits       = 0;
    end else begin
      // compare an accepted result word with the oldest expectation
      if (out_valid_i && !out_stall_i) begin
        if (awaited_words.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result word with nothing expected: count %0d status %0d",
                     $time, count_i, status_i);
          mismatches++;
        end else begin
          want = awaited_words.pop_front();
          if (count_i !== want.count || status_i !== want.status) begin
            if (mismatches < 10)
              $display("%0t: result %0d: expected count %0d status %0d, got count %0d status %0d",
                       $time, checked, want.count, want.status, count_i, status_i);
            mismatches++;
          end
          if (want.status == ST_BINNED) hits++;
          checked++;
        end
      end

      // predict each accepted input word
      if (in_valid_i && !in_stall_i)
        awaited_words.push_back(histogram_step(op_e'(operation_i), particle_index_i,
                                               time_now_i, velocity_i, vel_bin_i, time_bin_i));

      // register writes
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_WIN_LOW:  win_low  = longint'(signed'(cfg_data_i));
          CFG_WIN_HIGH: win_high = longint'(signed'(cfg_data_i));
          CFG_SPAN:     span     = cfg_data_i[SPAN_W-1:0];
          default: ;
        endcase
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= awaited_words.size();
    hits_o       <= hits;
  end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ttvh_pkg::*;

  localparam int SLOTS      = 4096;
  localparam int VEL_BINS   = 200;
  localparam int TIME_BINS  = 200;
  localparam int N_SETTINGS = 8;
  localparam int HOLD_LEN   = 400;
  localparam int POOL_MAX   = 48;

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index      = CFG_WIN_LOW;
  logic [CFG_DAT_W-1:0]  cfg_data       = '0;
  logic                  in_valid       = 1'b0;
  logic                  in_stall;
  logic [OP_W-1:0]       operation      = OP_RECORD;
  logic [IDX_W-1:0]      particle_index = '0;
  logic [TIME_W-1:0]     time_now       = '0;
  logic signed [VEL_W-1:0] velocity     = '0;
  logic [BIN_W-1:0]      vel_bin        = '0;
  logic [BIN_W-1:0]      time_bin       = '0;
  logic                  out_valid;
  logic                  out_stall      = 1'b0;
  logic [CNT_W-1:0]      count;
  logic [STAT_W-1:0]     status;

  int fail_count;
  int pending;
  int hits;

  // register settings per phase; the first one is the reset state
  longint set_low  [N_SETTINGS] = '{64'sd0, -64'sd4294967296, -64'sd140737488355328, 64'sd0,
                                    64'sd4294967296, 64'sd1073741824, -64'sd1048576, 64'sd0};
  longint set_high [N_SETTINGS] = '{64'sd4294967296, 64'sd4294967296, 64'sd140737488355327,
                                    64'sd16777216, -64'sd4294967296, 64'sd1073741824,
                                    64'sd17179869184, 64'sd4294967296};
  int set_span  [N_SETTINGS] = '{1000, 500, 65535, 200, 1, 300, 0, 1000};
  int set_vlo   [N_SETTINGS] = '{0, -65536, -8388608, 0, -65536, -65536, -70000, 0};
  int set_vhi   [N_SETTINGS] = '{65535, 65536, 8388607, 4096, 65536, 65536, 140000, 65535};
  int set_items [N_SETTINGS] = '{250, 200, 200, 200, 100, 100, 100, 250};

  // velocities and transit times that land on a few known cells at reset settings
  int focus_vel [3] = '{16384, 32768, 49152};
  int focus_dt  [3] = '{250, 500, 750};
  int focus_vb  [3] = '{12, 49, 111};
  int focus_tb  [3] = '{49, 99, 149};

  logic [TIME_W-1:0] rec_step [SLOTS];
  int                pool [$];
  int                clears_left = 4;
  int                words_sent  = 0;
  int                clears_sent = 0;
  bit                tx_idle     = 1'b1;
  logic              rx_idle     = 1'b1;
  int                hold_ask    = 0;
  int                hold_done   = 0;
  int                hold_cnt    = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  transit_time_velocity_histogram_top #(
    .SLOTS    (SLOTS),
    .VEL_BINS (VEL_BINS),
    .TIME_BINS(TIME_BINS)
  ) DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .operation_i     (operation),
    .particle_index_i(particle_index),
    .time_now_i      (time_now),
    .velocity_i      (velocity),
    .vel_bin_i       (vel_bin),
    .time_bin_i      (time_bin),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .count_o         (count),
    .status_o        (status)
  );

  ttvh_monitor #(
    .SLOTS    (SLOTS),
    .VEL_BINS (VEL_BINS),
    .TIME_BINS(TIME_BINS)
  ) u_monitor (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .operation_i     (operation),
    .particle_index_i(particle_index),
    .time_now_i      (time_now),
    .velocity_i      (velocity),
    .vel_bin_i       (vel_bin),
    .time_bin_i      (time_bin),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .count_i         (count),
    .status_i        (status),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .hits_o          (hits)
  );

  // result side: random stalls, plus a long hold when asked
  always @(posedge clk) begin
    if (hold_cnt != 0) begin
      out_stall <= 1'b1;
      hold_cnt  <= hold_cnt - 1;
    end else if (hold_ask != hold_done) begin
      out_stall <= 1'b1;
      hold_cnt  <= HOLD_LEN;
      hold_done <= hold_done + 1;
    end else begin
      out_stall <= rx_idle && ($urandom_range(0, 99) < 32);
    end
  end

  // offer one word, with a random gap first when tx_idle is set, and wait until it is taken
  task automatic send_word(op_e op, logic [IDX_W-1:0] idx, logic [TIME_W-1:0] now,
                           logic signed [VEL_W-1:0] vel, logic [BIN_W-1:0] vb,
                           logic [BIN_W-1:0] tb);
    int gap;
    gap = 0;
    if (tx_idle) while ($urandom_range(0, 99) < 32) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    operation      <= op;
    particle_index <= idx;
    time_now       <= now;
    velocity       <= vel;
    vel_bin        <= vb;
    time_bin       <= tb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    if (op == OP_CLEAR) clears_sent++;
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_settings(int ph);
    longint lo;
    longint hi;
    lo = set_low[ph];
    hi = set_high[ph];
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WIN_LOW;
    cfg_data  <= lo[CFG_DAT_W-1:0];
    @(posedge clk);
    cfg_index <= CFG_WIN_HIGH;
    cfg_data  <= hi[CFG_DAT_W-1:0];
    @(posedge clk);
    cfg_index <= CFG_SPAN;
    cfg_data  <= CFG_DAT_W'(set_span[ph]);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly record/exit pairs that land inside the bins, the rest noise
  task automatic random_word(int ph);
    op_e                     op;
    int                      s;
    int                      dt;
    int                      span_eff;
    logic [TIME_W-1:0]       now;
    logic signed [VEL_W-1:0] vel;
    logic [BIN_W-1:0]        vb;
    logic [BIN_W-1:0]        tb;
    int                      pick;
    pick = $urandom_range(0, 99);
    s    = $urandom_range(0, SLOTS - 1);
    now  = TIME_W'($urandom);
    vel  = VEL_W'($urandom);
    vb   = BIN_W'($urandom);
    tb   = BIN_W'($urandom);
    span_eff = (set_span[ph] == 0) ? 1000 : ((set_span[ph] > 35000) ? 35000 : set_span[ph]);
    if (clears_left > 0 && $urandom_range(0, 299) == 0) begin
      op = OP_CLEAR;
      clears_left--;
      pool.delete();
    end else if (pick < 36) begin
      op = OP_RECORD;
      if ($urandom_range(0, 99) < 85)
        vel = VEL_W'(set_vlo[ph] + int'($urandom_range(0, set_vhi[ph] - set_vlo[ph])));
      if (ph == 0 && $urandom_range(0, 1) == 1) vel = VEL_W'(focus_vel[$urandom_range(0, 2)]);
      if ($urandom_range(0, 99) < 90) now = TIME_W'($urandom_range(1, 29000));
      // overwrite a live slot now and then
      if (pool.size() > 0 && $urandom_range(0, 99) < 30) s = pool[$urandom_range(0, pool.size() - 1)];
      if (now != '0) begin
        rec_step[s] = now;
        if (pool.size() >= POOL_MAX) void'(pool.pop_front());
        pool.push_back(s);
      end
    end else if (pick < 76) begin
      op = OP_EXIT;
      if (pool.size() > 0 && $urandom_range(0, 99) < 85) begin
        s  = pool[$urandom_range(0, pool.size() - 1)];
        dt = $urandom_range(1, span_eff);
        if (ph == 0 && $urandom_range(0, 1) == 1) dt = focus_dt[$urandom_range(0, 2)];
        else if ($urandom_range(0, 99) < 8) dt = $urandom_range(0, 65535);
        now = rec_step[s] + dt[TIME_W-1:0];
      end
    end else begin
      op = OP_READ;
      if (ph == 0 && $urandom_range(0, 1) == 1) begin
        vb = BIN_W'(focus_vb[$urandom_range(0, 2)]);
        tb = BIN_W'(focus_tb[$urandom_range(0, 2)]);
      end else if ($urandom_range(0, 99) < 75) begin
        vb = BIN_W'($urandom_range(0, VEL_BINS - 1));
        tb = BIN_W'($urandom_range(0, TIME_BINS - 1));
      end
    end
    send_word(op, IDX_W'(s), now, vel, vb, tb);
  endtask

  initial begin : stimulus
    int ph;
    int i;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words at reset settings
    send_word(OP_READ,   12'd0,    16'd0,     24'sd0,        8'd0,   8'd0);
    send_word(OP_READ,   12'd0,    16'd0,     24'sd0,        8'd255, 8'd255);
    send_word(OP_READ,   12'd0,    16'd0,     24'sd0,        8'd199, 8'd5);
    send_word(OP_READ,   12'd0,    16'd0,     24'sd0,        8'd5,   8'd199);
    // exit with no entry
    send_word(OP_EXIT,   12'd5,    16'd700,   24'sd0,        8'd0,   8'd0);
    // good transit, then the same exit again since exit keeps the entry
    send_word(OP_RECORD, 12'd4095, 16'd1,     24'sd32768,    8'd0,   8'd0);
    send_word(OP_EXIT,   12'd4095, 16'd501,   24'sd0,        8'd0,   8'd0);
    send_word(OP_EXIT,   12'd4095, 16'd501,   24'sd0,        8'd0,   8'd0);
    send_word(OP_READ,   12'd0,    16'd0,     24'sd0,        8'd49,  8'd99);
    // largest velocity falls beyond the window
    send_word(OP_RECORD, 12'd0,    16'd100,   24'sd8388607,  8'd0,   8'd0);
    send_word(OP_EXIT,   12'd0,    16'd600,   24'sd0,        8'd0,   8'd0);
    // zero velocity lands on the low edge bin
    send_word(OP_RECORD, 12'd7,    16'd10,    24'sd0,        8'd0,   8'd0);
    send_word(OP_EXIT,   12'd7,    16'd510,   24'sd0,        8'd0,   8'd0);
    // most negative velocity
    send_word(OP_RECORD, 12'd8,    16'd10,    -24'sd8388608, 8'd0,   8'd0);
    send_word(OP_EXIT,   12'd8,    16'd510,   24'sd0,        8'd0,   8'd0);
    // record at step zero reads as no entry
    send_word(OP_RECORD, 12'd9,    16'd0,     24'sd32768,    8'd0,   8'd0);
    send_word(OP_EXIT,   12'd9,    16'd500,   24'sd0,        8'd0,   8'd0);
    // exit earlier than entry gives a negative transit time
    send_word(OP_RECORD, 12'd10,   16'd65535, 24'sd32768,    8'd0,   8'd0);
    send_word(OP_EXIT,   12'd10,   16'd0,     24'sd0,        8'd0,   8'd0);
    // negative velocity below the window
    send_word(OP_RECORD, 12'd11,   16'd1,     -24'sd32768,   8'd0,   8'd0);
    send_word(OP_EXIT,   12'd11,   16'd501,   24'sd0,        8'd0,   8'd0);
    // transit time and velocity in the last bin below the top edge
    send_word(OP_RECORD, 12'd12,   16'd2,     24'sd65535,    8'd0,   8'd0);
    send_word(OP_EXIT,   12'd12,   16'd1001,  24'sd0,        8'd0,   8'd0);
    // clear wipes counts and entries
    send_word(OP_CLEAR,  12'd0,    16'd0,     24'sd0,        8'd0,   8'd0);
    send_word(OP_READ,   12'd0,    16'd0,     24'sd0,        8'd49,  8'd99);
    send_word(OP_EXIT,   12'd4095, 16'd501,   24'sd0,        8'd0,   8'd0);

    // random phases, one register setting each
    for (ph = 0; ph < N_SETTINGS; ph++) begin
      drain();
      if (ph > 0) load_settings(ph);
      tx_idle = (ph != 3);
      rx_idle <= (ph != 3);
      for (i = 0; i < set_items[ph]; i++) begin
        if (ph == 1 && i == 40) hold_ask <= hold_ask + 1;
        random_word(ph);
      end
    end
    drain();

    $display("covered %0d words over %0d register settings with %0d clears and one long hold",
             words_sent, N_SETTINGS, clears_sent);
    $display("%0d histogram increments seen, %0d mismatches", hits, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // run limit
  initial begin
    #40_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
